[rtl/core/ctt_pkg.sv]
package ctt_pkg;

    localparam int LEX_MAX_RES = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    // keyword text, first byte in the low octet
    localparam logic [47:0] KW_EVENT  = 48'h0074_6E65_7665;
    localparam logic [47:0] KW_SOURCE = 48'h6563_7275_6F73;
    localparam logic [47:0] KW_OUTPUT = 48'h7475_7074_756F;
    localparam logic [47:0] KW_PLUGIN = 48'h6E69_6775_6C70;

    typedef enum logic [3:0] {
        M_IDLE,
        M_NAME,
        M_VALUE,
        M_STRING,
        M_HASH,
        M_SLASH,
        M_BLOCK,
        M_BLOCK_STAR,
        M_EOL,
        M_EOL_CR,
        M_CR
    } t_mode;

    typedef enum logic [3:0] {
        K_UNKNOWN = 4'd0,
        K_EOF     = 4'd1,
        K_EOL     = 4'd2,
        K_NAME    = 4'd3,
        K_VALUE   = 4'd4,
        K_EVENT   = 4'd5,
        K_SOURCE  = 4'd6,
        K_OUTPUT  = 4'd7,
        K_PLUGIN  = 4'd8
    } t_kind;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_input;
    } t_in_word;

    typedef struct packed {
        logic        is_text;
        logic [7:0]  text_char;
        logic [3:0]  token_kind;
        logic [15:0] token_line;
        logic [15:0] token_column;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0]                       count;
        t_result [LEX_MAX_RES-1:0]        word;
    } t_batch;

    typedef struct packed {
        logic [FIFO_AW:0] level;
        logic             room;
    } t_fifo_status;

endpackage

[rtl/core/ctt_stream_if.sv]
interface ctt_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/ctt_lexer.sv]
module ctt_lexer
    import ctt_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_word i_word,
    output t_batch   o_batch
);

    localparam logic [POSITION_BITS-1:0] PMAX = '1;

    t_mode                    r_mode, n_mode;
    logic [7:0]               r_delim, n_delim;
    logic [7:0]               r_prev, n_prev;
    logic [47:0]              r_kbuf, n_kbuf;
    logic [2:0]               r_nlen, n_nlen;
    logic [POSITION_BITS-1:0] r_line, n_line;
    logic [POSITION_BITS-1:0] r_col, n_col;
    logic [POSITION_BITS-1:0] r_sl, n_sl;
    logic [POSITION_BITS-1:0] r_sc, n_sc;

    function automatic logic [15:0] pos16(input logic [POSITION_BITS-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return w[15:0];
    endfunction

    function automatic t_result mk(input logic is_text, input logic [7:0] ch,
                                   input t_kind kind,
                                   input logic [POSITION_BITS-1:0] line,
                                   input logic [POSITION_BITS-1:0] col);
        t_result r;
        r.is_text      = is_text;
        r.text_char    = ch;
        r.token_kind   = kind;
        r.token_line   = pos16(line);
        r.token_column = pos16(col);
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || b == CH_UNDER || b == CH_DOT || b == CH_COLON;
    endfunction

    function automatic t_kind name_kind(input logic [2:0] nlen, input logic [47:0] kbuf);
        t_kind k;
        k = K_NAME;
        if (nlen == 3'd5 && kbuf == KW_EVENT) k = K_EVENT;
        if (nlen == 3'd6) begin
            if (kbuf == KW_SOURCE) k = K_SOURCE;
            else if (kbuf == KW_OUTPUT) k = K_OUTPUT;
            else if (kbuf == KW_PLUGIN) k = K_PLUGIN;
        end
        return k;
    endfunction

    always_comb begin
        logic [7:0]               b;
        logic [POSITION_BITS-1:0] pl, pc;
        logic                     do_idle, do_str;
        logic [1:0]               cnt;
        t_result                  res [LEX_MAX_RES+1];

        b       = i_word.text_byte;
        pl      = r_line;
        pc      = (r_col < PMAX) ? r_col + 1'b1 : PMAX;
        do_idle = 1'b0;
        do_str  = 1'b0;
        cnt     = '0;
        for (int i = 0; i <= LEX_MAX_RES; i++) res[i] = '0;

        n_mode  = r_mode;
        n_delim = r_delim;
        n_prev  = r_prev;
        n_kbuf  = r_kbuf;
        n_nlen  = r_nlen;
        n_line  = r_line;
        n_col   = r_col;
        n_sl    = r_sl;
        n_sc    = r_sc;

        if (i_word.end_of_input) begin
            case (r_mode)
                M_NAME: begin
                    res[cnt] = mk(1'b0, 8'h00, name_kind(r_nlen, r_kbuf), n_sl, n_sc);
                    cnt++;
                end
                M_VALUE: begin
                    res[cnt] = mk(1'b0, 8'h00, K_VALUE, n_sl, n_sc);
                    cnt++;
                end
                M_STRING, M_SLASH, M_CR: begin
                    res[cnt] = mk(1'b0, 8'h00, K_UNKNOWN, n_sl, n_sc);
                    cnt++;
                end
                M_EOL: begin
                    res[cnt] = mk(1'b0, 8'h00, K_EOL, n_sl, n_sc);
                    cnt++;
                end
                M_EOL_CR: begin
                    res[cnt] = mk(1'b0, 8'h00, K_EOL, n_sl, n_sc);
                    cnt++;
                    res[cnt] = mk(1'b0, 8'h00, K_UNKNOWN, r_line, r_col);
                    cnt++;
                end
                default: ;
            endcase
            n_mode   = M_IDLE;
            res[cnt] = mk(1'b0, 8'h00, K_EOF, pl, pc);
            cnt++;
        end else begin
            if (b == CH_LF) begin
                if (r_line < PMAX) n_line = r_line + 1'b1;
                n_col = '0;
            end else begin
                n_col = pc;
            end

            case (r_mode)
                M_NAME, M_VALUE: begin
                    if (is_word(b)) begin
                        if (r_mode == M_NAME) begin
                            if (r_nlen < 3'd6) begin
                                n_kbuf[{r_nlen, 3'b000} +: 8] = b;
                                n_nlen = r_nlen + 3'd1;
                            end else begin
                                n_nlen = 3'd7;
                            end
                        end
                        res[cnt] = mk(1'b1, b, K_UNKNOWN, n_sl, n_sc);
                        cnt++;
                    end else begin
                        res[cnt] = mk(1'b0, 8'h00,
                                      (r_mode == M_NAME) ? name_kind(r_nlen, r_kbuf) : K_VALUE,
                                      n_sl, n_sc);
                        cnt++;
                        do_idle = 1'b1;
                    end
                end
                M_STRING: do_str = 1'b1;
                M_HASH: begin
                    if (b == CH_LF || b == CH_CR) do_idle = 1'b1;
                end
                M_SLASH: begin
                    if (b == CH_STAR) begin
                        n_mode = M_BLOCK_STAR;
                    end else begin
                        n_delim = CH_SLASH;
                        n_prev  = 8'h00;
                        n_mode  = M_STRING;
                        do_str  = 1'b1;
                    end
                end
                M_BLOCK: begin
                    if (b == CH_STAR) n_mode = M_BLOCK_STAR;
                end
                M_BLOCK_STAR: begin
                    if (b == CH_SLASH) n_mode = M_IDLE;
                    else if (b != CH_STAR) n_mode = M_BLOCK;
                end
                M_EOL: begin
                    if (b == CH_CR) begin
                        n_mode = M_EOL_CR;
                    end else if (b != CH_LF) begin
                        res[cnt] = mk(1'b0, 8'h00, K_EOL, n_sl, n_sc);
                        cnt++;
                        do_idle = 1'b1;
                    end
                end
                M_EOL_CR: begin
                    if (b == CH_LF) begin
                        n_mode = M_EOL;
                    end else begin
                        res[cnt] = mk(1'b0, 8'h00, K_EOL, n_sl, n_sc);
                        cnt++;
                        // the lone CR sits where the previous byte was counted
                        res[cnt] = mk(1'b0, 8'h00, K_UNKNOWN, r_line, r_col);
                        cnt++;
                        do_idle = 1'b1;
                    end
                end
                M_CR: begin
                    if (b == CH_LF) begin
                        n_mode = M_EOL;
                    end else begin
                        res[cnt] = mk(1'b0, 8'h00, K_UNKNOWN, n_sl, n_sc);
                        cnt++;
                        do_idle = 1'b1;
                    end
                end
                default: do_idle = 1'b1;
            endcase

            if (do_str) begin
                if (b == n_delim && n_prev != CH_BSLASH) begin
                    res[cnt] = mk(1'b0, 8'h00, K_VALUE, n_sl, n_sc);
                    cnt++;
                    n_mode = M_IDLE;
                end else begin
                    res[cnt] = mk(1'b1, b, K_UNKNOWN, n_sl, n_sc);
                    cnt++;
                    n_prev = b;
                end
            end

            if (do_idle) begin
                n_mode = M_IDLE;
                if (b == CH_LF || b == CH_CR) begin
                    n_sl   = pl;
                    n_sc   = pc;
                    n_mode = (b == CH_LF) ? M_EOL : M_CR;
                end else if (b <= CH_SPACE || b >= CH_DEL) begin
                    n_mode = M_IDLE;
                end else if (b == CH_HASH) begin
                    n_mode = M_HASH;
                end else begin
                    n_sl = pl;
                    n_sc = pc;
                    if (b == CH_SLASH) begin
                        n_mode = M_SLASH;
                    end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                        n_delim = b;
                        n_prev  = 8'h00;
                        n_mode  = M_STRING;
                    end else if (is_alpha(b)) begin
                        n_kbuf = {40'h0, b};
                        n_nlen = 3'd1;
                        n_mode = M_NAME;
                        res[cnt] = mk(1'b1, b, K_UNKNOWN, n_sl, n_sc);
                        cnt++;
                    end else if (is_digit(b)) begin
                        n_mode = M_VALUE;
                        res[cnt] = mk(1'b1, b, K_UNKNOWN, n_sl, n_sc);
                        cnt++;
                    end else begin
                        res[cnt] = mk(1'b0, 8'h00, K_UNKNOWN, n_sl, n_sc);
                        cnt++;
                    end
                end
            end
        end

        if (cnt != 2'd0) res[cnt - 2'd1].last_of_run = 1'b1;

        o_batch.count = i_step ? cnt : 2'd0;
        for (int i = 0; i < LEX_MAX_RES; i++) o_batch.word[i] = res[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_delim <= '0;
            r_prev  <= '0;
            r_kbuf  <= '0;
            r_nlen  <= '0;
            r_line  <= POSITION_BITS'(1);
            r_col   <= '0;
            r_sl    <= POSITION_BITS'(1);
            r_sc    <= POSITION_BITS'(1);
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_delim <= n_delim;
            r_prev  <= n_prev;
            r_kbuf  <= n_kbuf;
            r_nlen  <= n_nlen;
            r_line  <= n_line;
            r_col   <= n_col;
            r_sl    <= n_sl;
            r_sc    <= n_sc;
        end
    end

endmodule

[rtl/core/ctt_result_fifo.sv]
module ctt_result_fifo
    import ctt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_batch       i_batch,
    input  logic         i_pop,
    output t_result      o_head,
    output t_fifo_status o_status
);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, r_rptr;
    logic [FIFO_AW:0]   r_level, n_level;
    logic               pop;

    assign pop     = i_pop && (r_level != '0);
    assign n_level = r_level + (FIFO_AW+1)'(i_batch.count) - (FIFO_AW+1)'(pop);

    // room for a whole batch, judged before this cycle's pop
    assign o_status.level = r_level;
    assign o_status.room  = r_level <= (FIFO_AW+1)'(FIFO_DEPTH - LEX_MAX_RES);
    assign o_head         = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LEX_MAX_RES; i++) begin
            if (2'(i) < i_batch.count) r_mem[r_wptr + FIFO_AW'(i)] <= i_batch.word[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_wptr  <= r_wptr + FIFO_AW'(i_batch.count);
            r_rptr  <= r_rptr + FIFO_AW'(pop);
            r_level <= n_level;
        end
    end

endmodule

[rtl/core/config_text_tokenizer.sv]
// Streaming tokenizer for configuration text.
// Input channel i_in carries one word per text byte: text_byte plus an
// end_of_input mark. Output channel o_out carries result words: token text
// bytes (is_text = 1) and then the token result with kind, start line and
// start column; last_of_run flags the final word caused by one input word.
// An input word may cause zero to three result words.
// An accepted byte is held in the input register and lexed when the lexer
// steps; its result words are registered in the queue and offered from it.
// Throughput: one input word per cycle while each produces at most one
// result and o_out.ready is high; the output side moves one result word
// per cycle, so bytes that close one token and start another slow the input.
// The lexer steps only when the eight-word result queue has room for a full
// batch of three; otherwise the input register holds and i_in.ready drops.
// A stalled receiver just fills the queue; nothing is lost or reordered.
// Reset (synchronous, active low) empties the queue and returns the lexer to
// idle at line 1, column 0.
module config_text_tokenizer
    import ctt_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ctt_stream_if.sink   i_in,
    ctt_stream_if.source o_out
);

    logic         r_in_valid;
    t_in_word     r_in;
    logic         step;
    t_batch       batch;
    t_fifo_status status;
    t_result      head;

    assign step       = r_in_valid && status.room;
    assign i_in.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) r_in <= i_in.payload;
    end

    ctt_lexer #(
        .POSITION_BITS(POSITION_BITS)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_word  (r_in),
        .o_batch (batch)
    );

    ctt_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_batch  (batch),
        .i_pop    (o_out.ready),
        .o_head   (head),
        .o_status (status)
    );

    assign o_out.valid   = status.level != '0;
    assign o_out.payload = head;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.level <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_eof_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_in.end_of_input |=> o_out.valid)
        else $error("end of input gave no result");

    a_step_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> status.level <= (FIFO_AW+1)'(FIFO_DEPTH - LEX_MAX_RES))
        else $error("lexer stepped without room for a batch");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_in_valid && !status.room)
        else $error("input stalled with lexer free");

endmodule
